@@ src/wrs_pkg.sv @@
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the weighted roulette select unit
// Sizes of the weight store, the scale of the shares and the derived widths,
// the result status codes, the controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // Store depth and scale of the per-entry shares.
  localparam int MAX_ENTRIES = 64;
  localparam int SCALE       = 1000;

  // Fixed field widths of the stream items.
  localparam int WEIGHT_W  = 16;
  localparam int PICK_W    = 10;
  localparam int OUT_IDX_W = 6;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 32;  // weight and pick, padded to whole bytes
  localparam int OUT_DATA_W = 8;   // chosen index and status

  // Derived widths.
  localparam int IDX_W   = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W   = WEIGHT_W + IDX_W;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int PROD_W  = WEIGHT_W + SCALE_W;
  localparam int DCNT_W  = $clog2(PROD_W);
  localparam int RUN_W   = SCALE_W + 1;
  localparam int CMP_W   = (RUN_W > PICK_W) ? RUN_W : PICK_W;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_MUL,
    S_DIV,
    S_ACC,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // input channel open
    logic rd;         // read the current entry
    logic walk_end;   // walk ran out: choose the last entry
    logic div_init;   // scale the entry and load the divider
    logic div_step;   // one restoring division step
    logic acc;        // add the share to the running total
    logic finish;     // write the result register, clear the list
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_acc;   // last item taken in this cycle
    logic res_ok;     // that list needs a walk
    logic walk_last;  // current index is the final entry
    logic div_done;   // final division step in this cycle
    logic hit;        // running total reaches the pick
    logic out_free;   // result register can take a result
  } stat_t;

endpackage

@@ src/weighted_roulette_select_unit.sv @@
// ----------------------------------------------------------------------------
// weighted_roulette_select_unit: weighted roulette wheel selection
// Loads a list of weights, then walks them with scaled shares and returns
// the first index whose running share total reaches the pick.
//
//   Channel  Direction  Payload
//   in_*     input      tdata: weight[15:0], pick[25:16]; tuser: entry_valid;
//                       tlast: is_last
//   out_*    output     tdata: chosen_index[5:0], status[7:6]
//
// Items that are not last are taken one per cycle. A last item of a list
// with a nonzero total starts the walk: each entry it divides is read,
// scaled, run through 26 divider steps and accumulated, and the final entry
// is taken undivided; the result is written once the output register is free.
// Reset is synchronous and active low; it empties the list and drops a
// pending result. While a stalled result sits in the output register, the
// next walk completes and then waits, and the input stays closed until the
// output register frees up.
// ----------------------------------------------------------------------------
module weighted_roulette_select_unit
  import wrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // weight, pick, zero padding
  input  logic                  in_tuser,   // entry_valid
  input  logic                  in_tlast,   // is_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // chosen_index, status
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  wrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Store, divider and output register.
  wrs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/wrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// wrs_ctrl: controller of the weighted roulette select unit
// Sequences loading, the walk over the stored weights (read, scale, divide,
// accumulate) and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module wrs_ctrl
  import wrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.last_acc) begin
          state_nxt = stat.res_ok ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        if (stat.walk_last) begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.hit ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

@@ src/wrs_datapath.sv @@
// ----------------------------------------------------------------------------
// wrs_datapath: datapath of the weighted roulette select unit
// Weight store, entry count and weight total, a registered scaling multiply,
// a restoring divider that takes one quotient bit per cycle, the running
// total with its compare against the pick, and the output register.
// ----------------------------------------------------------------------------
module wrs_datapath
  import wrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [WEIGHT_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]    count_r;
  logic [TOT_W-1:0]    total_r;
  logic [PICK_W-1:0]   pick_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    sel_r;
  status_t             res_status_r;
  logic [WEIGHT_W-1:0] rdata_r;
  logic [TOT_W-1:0]    rem_r;
  logic [PROD_W-1:0]   dvd_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic [RUN_W-1:0]    running_r;
  logic                out_valid_r;
  logic [OUT_IDX_W-1:0] out_index_r;
  status_t             out_status_r;

  logic [WEIGHT_W-1:0] in_weight;
  logic [PICK_W-1:0]   in_pick;
  logic                accept;
  logic                add_en;
  logic [TOT_W-1:0]    total_nxt;
  logic [CNT_W-1:0]    count_nxt;
  status_t             res_status_nxt;
  logic [TOT_W:0]      rem_sh;
  logic [TOT_W:0]      rem_diff;
  logic                q_bit;
  logic [RUN_W-1:0]    running_nxt;
  logic [CNT_W-1:0]    idx_inc;
  logic [CNT_W-1:0]    last_idx;
  logic [IDX_W+OUT_IDX_W-1:0] sel_ext;

  // Input unpacking and the load handshake.
  assign in_weight = in_tdata[WEIGHT_W-1:0];
  assign in_pick   = in_tdata[WEIGHT_W +: PICK_W];
  assign in_tready = cmd.load;
  assign accept    = in_tvalid && cmd.load;
  assign add_en    = accept && in_tuser && (count_r < CNT_W'(MAX_ENTRIES));
  assign total_nxt = total_r + TOT_W'(in_weight);
  assign count_nxt = count_r + CNT_W'(1);

  // Outcome of a list, taken from the count and total including this item.
  always_comb begin
    if ((count_r == '0) && !add_en) begin
      res_status_nxt = ST_EMPTY;
    end else if ((add_en ? total_nxt : total_r) == '0) begin
      res_status_nxt = ST_ZERO;
    end else begin
      res_status_nxt = ST_OK;
    end
  end

  // Weight store write port.
  always_ff @(posedge clk) begin
    if (add_en) begin
      mem[count_r[IDX_W-1:0]] <= in_weight;
    end
  end

  // Weight store read port with registered data.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[idx_r];
    end
  end

  // Entry count and weight total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.finish) begin
      count_r <= '0;
      total_r <= '0;
    end else if (add_en) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // Walk bookkeeping: pick, index, running total and selected entry.
  assign idx_inc     = CNT_W'(idx_r) + CNT_W'(1);
  assign last_idx    = count_r - CNT_W'(1);
  assign running_nxt = running_r + dvd_r[RUN_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      pick_r       <= in_pick;
      res_status_r <= res_status_nxt;
      idx_r        <= '0;
      sel_r        <= '0;
      running_r    <= '0;
    end else begin
      if (cmd.walk_end) begin
        sel_r <= last_idx[IDX_W-1:0];
      end
      if (cmd.acc) begin
        running_r <= running_nxt;
        if (stat.hit) begin
          sel_r <= idx_r;
        end else begin
          idx_r <= idx_inc[IDX_W-1:0];
        end
      end
    end
  end

  // Restoring divider: share = weight * SCALE / total, one bit per cycle.
  assign rem_sh   = {rem_r, dvd_r[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, total_r};
  assign q_bit    = (rem_sh >= {1'b0, total_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r  <= PROD_W'(rdata_r) * PROD_W'(SCALE);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[PROD_W-2:0], q_bit};
      rem_r  <= q_bit ? rem_diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // Output register; it frees up in the cycle its transfer completes.
  assign sel_ext = {{OUT_IDX_W{1'b0}}, sel_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_index_r  <= sel_ext[OUT_IDX_W-1:0];
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_index_r};

  // Status toward the controller.
  assign stat.last_acc  = accept && in_tlast;
  assign stat.res_ok    = (res_status_nxt == ST_OK);
  assign stat.walk_last = (idx_inc >= count_r);
  assign stat.div_done  = (dcnt_r == DCNT_W'(PROD_W - 1));
  assign stat.hit       = (CMP_W'(running_nxt) >= CMP_W'(pick_r));
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the weighted roulette select unit
// Streams weight lists into the unit, predicts each selection from a private
// copy of the list, and compares every result transfer with the oldest
// prediction. Directed lists cover the corner cases. Random lists follow, with
// random idling on both sides, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import wrs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_TARGET = 1900;
  localparam int LONG_HOLD     = 3000;
  localparam int END_WAIT      = MAX_ENTRIES * 29 + 50;
  localparam int PAD_W         = IN_DATA_W - WEIGHT_W - PICK_W;

  // Weight shapes used by the list generator.
  typedef enum int {
    WM_FULL,
    WM_SMALL,
    WM_ZERO,
    WM_SPARSE,
    WM_MAX
  } weight_mode_t;

  // One predicted selection.
  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    status_t              status;
  } choice_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // weight, pick, zero padding
  logic                  in_tuser = 1'b0; // entry_valid
  logic                  in_tlast = 1'b0; // is_last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // chosen_index, status

  // Private copy of the list being loaded.
  logic [WEIGHT_W-1:0] list_weights [MAX_ENTRIES];
  int unsigned         list_len = 0;
  longint unsigned     list_sum = 0;

  choice_t expected_choices [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  int      hold_request = 0;
  bit      burst_mode = 1'b0;

  weighted_roulette_select_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Walk the stored list and pick the first entry whose running share total
  // reaches the pick; the last entry is the fallback.
  function automatic choice_t roulette_choose(logic [PICK_W-1:0] pick);
    choice_t         c;
    longint unsigned running;
    bit              found;
    c.index = '0;
    running = 0;
    found   = 1'b0;
    if (list_len == 0) begin
      c.status = ST_EMPTY;
    end else if (list_sum == 0) begin
      c.status = ST_ZERO;
    end else begin
      c.status = ST_OK;
      c.index  = OUT_IDX_W'(list_len - 1);
      for (int i = 0; i + 1 < list_len; i++) begin
        if (!found) begin
          running += (longint'(list_weights[i]) * SCALE) / list_sum;
          if (running >= pick) begin
            c.index = OUT_IDX_W'(i);
            found   = 1'b1;
          end
        end
      end
    end
    return c;
  endfunction

  // Update the list copy for one accepted transfer.
  task automatic note_transfer(logic [WEIGHT_W-1:0] weight, bit valid, bit last,
                               logic [PICK_W-1:0] pick);
    if (valid && list_len < MAX_ENTRIES) begin
      list_weights[list_len] = weight;
      list_len++;
      list_sum += weight;
    end
    if (last) begin
      expected_choices.push_back(roulette_choose(pick));
      list_len = 0;
      list_sum = 0;
    end
  endtask

  // Offer one item after a random gap (none in burst mode) and wait for its transfer.
  task automatic send_item(logic [WEIGHT_W-1:0] weight, bit valid, bit last,
                           logic [PICK_W-1:0] pick);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, pick, weight};
    in_tuser  <= valid;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    note_transfer(weight, valid, last, pick);
    if (valid || last) items_sent++;
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_choices.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] draw_weight(weight_mode_t mode);
    case (mode)
      WM_SMALL:  return WEIGHT_W'($urandom_range(0, 15));
      WM_ZERO:   return '0;
      WM_SPARSE: return ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom) : '0;
      WM_MAX:    return '1;
      default:   return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Mostly legal picks, with zero and values above the scale now and then.
  function automatic logic [PICK_W-1:0] draw_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return PICK_W'($urandom_range(1, SCALE));
    if (r < 85) return '0;
    if (r < 90) return PICK_W'($urandom_range(SCALE + 1, (1 << PICK_W) - 1));
    return PICK_W'($urandom);
  endfunction

  // Send a list of random weights, ended either by the last weight or by an
  // extra item that carries no weight. Ignored items are mixed in as noise.
  task automatic send_list(int n_weights, weight_mode_t mode, bit invalid_end);
    bit last;
    for (int k = 0; k < n_weights; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(WEIGHT_W'($urandom), 1'b0, 1'b0, PICK_W'($urandom));
      last = !invalid_end && (k == n_weights - 1);
      send_item(draw_weight(mode), 1'b1, last, last ? draw_pick() : PICK_W'($urandom));
    end
    if (invalid_end)
      send_item(WEIGHT_W'($urandom), 1'b0, 1'b1, draw_pick());
  endtask

  // Result side: random stalls, a long hold-off on request, and the check of
  // every result transfer against the oldest prediction.
  initial begin : result_monitor
    int      stall;
    choice_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_choices.size() == 0) begin
        $error("unexpected result transfer: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_choices.pop_front();
        if (out_tdata[OUT_IDX_W-1:0] !== want.index) begin
          $error("chosen_index mismatch: expected %0d, actual %0d",
                 want.index, out_tdata[OUT_IDX_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OUT_DATA_W-1 -: STATUS_W] !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want.status, out_tdata[OUT_DATA_W-1 -: STATUS_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Corner cases: empty list, zero total, extreme weights and picks.
  task automatic test_directed_cases();
    send_item(16'h1234, 1'b0, 1'b0, 10'd5);        // ignored item
    send_item(16'hFFFF, 1'b0, 1'b1, 10'd500);      // empty list
    send_item(16'hFFFF, 1'b1, 1'b1, 10'd1);        // single entry
    send_item(16'h0000, 1'b1, 1'b0, 10'd0);        // all-zero weights
    send_item(16'h0000, 1'b1, 1'b0, 10'd0);
    send_item(16'h0000, 1'b1, 1'b1, 10'd700);
    send_item(16'hFFFF, 1'b1, 1'b0, 10'd0);        // pick of zero
    send_item(16'hFFFF, 1'b1, 1'b1, 10'd0);
    send_item(16'd1, 1'b1, 1'b0, 10'd0);           // pick above the scale
    send_item(16'd1, 1'b1, 1'b0, 10'd0);
    send_item(16'd1, 1'b1, 1'b1, 10'd1023);
    send_item(16'd100, 1'b1, 1'b0, 10'd0);         // pick at the scale
    send_item(16'd200, 1'b1, 1'b0, 10'd0);
    send_item(16'd700, 1'b1, 1'b1, 10'd1000);
    send_item(16'd500, 1'b1, 1'b0, 10'd0);         // ended by an item without weight
    send_item(16'd500, 1'b1, 1'b0, 10'd0);
    send_item(16'h5A5A, 1'b0, 1'b1, 10'd300);
    send_item(16'd0, 1'b1, 1'b0, 10'd0);           // zero share ahead of a full one
    send_item(16'hFFFF, 1'b1, 1'b1, 10'd1);
    wait_drain();
  endtask

  // Weights beyond the store depth are dropped, but their last marker counts.
  task automatic test_store_full();
    send_list(MAX_ENTRIES + 2, WM_FULL, 1'b0);
    send_list(MAX_ENTRIES, WM_SMALL, 1'b1);
    send_list(MAX_ENTRIES + 1, WM_SPARSE, 1'b1);
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while lists keep coming.
  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    repeat (6) send_list($urandom_range(2, 8), WM_FULL, 1'b0);
    wait_drain();
  endtask

  // The sender waits for every result before the next lists.
  task automatic test_drain_pause();
    repeat (3) begin
      send_list($urandom_range(1, 6), WM_FULL, 1'b0);
      wait_drain();
    end
  endtask

  // Random lists, mostly short, some long, a few overflowing the store.
  task automatic test_random_lists();
    int           r;
    int           n;
    bit           inv_end;
    weight_mode_t mode;
    int           lists_done;
    lists_done = 0;
    while (items_sent < RANDOM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5)       n = 0;
      else if (r < 75) n = $urandom_range(1, 8);
      else if (r < 93) n = $urandom_range(9, 24);
      else if (r < 98) n = $urandom_range(25, MAX_ENTRIES);
      else             n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 6);
      inv_end = (n == 0) || ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 55)      mode = WM_FULL;
      else if (r < 75) mode = WM_SMALL;
      else if (r < 82) mode = WM_ZERO;
      else if (r < 95) mode = WM_SPARSE;
      else             mode = WM_MAX;
      // Stretches without idling on either side.
      if (lists_done % 40 == 10) burst_mode = 1'b1;
      if (lists_done % 40 == 18) burst_mode = 1'b0;
      send_list(n, mode, inv_end);
      lists_done++;
    end
    burst_mode = 1'b0;
  endtask

  // Test sequence.
  initial begin : test_sequence
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_store_full();
    test_backpressure();
    test_drain_pause();
    test_random_lists();
    wait_drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
